[rtl/core/nwpa_pkg.sv]
package nwpa_pkg;

    localparam int SYN_W      = 16;
    localparam int TOT_W      = 32;
    localparam int NODE_IDX_W = 5;
    localparam int OUT_W      = 4;
    localparam int LOAD_W     = 40;
    localparam int LOAD_WEIGHT = 100;
    localparam int QUOTA_W    = NODE_IDX_W + 1 + TOT_W;

    localparam logic [1:0] REG_MODE       = 2'd0;
    localparam logic [1:0] REG_NODE_COUNT = 2'd1;
    localparam logic [1:0] REG_QUOTA      = 2'd2;

    localparam logic [1:0] MODE_BLOCK     = 2'd0;
    localparam logic [1:0] MODE_RR        = 2'd1;
    localparam logic [1:0] MODE_GROUP_RR  = 2'd2;
    localparam logic [1:0] MODE_BEST_FIT  = 2'd3;

    typedef struct packed {
        logic                  vld;
        logic [LOAD_W-1:0]     best;
        logic [NODE_IDX_W-1:0] idx;
    } token_t;

    typedef struct packed {
        logic                  vld;
        logic [NODE_IDX_W-1:0] idx;
        logic [SYN_W-1:0]      syn;
    } upd_t;

    function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
                                                 input logic [TOT_W-1:0] b);
        logic [TOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
    endfunction

endpackage

[rtl/core/network_partition_assigner.sv]
// Neuron-to-node partition assigner.
// Input channel (in_valid/in_stall) takes one neuron word carrying its
// syn_count; output channel (out_valid/out_stall) returns one node word
// per neuron, in order. Configuration writes (cfg_valid/cfg_ready, always
// ready) set mode, node_count and neurons_per_node; the user must do so only
// while the block is idle, which the block itself does not enforce.
// One neuron is worked at a time. States: block balance calc, step, done;
// round robin and group round robin calc, done; a single node only done.
// Best fit: a search token walks the chain of per-node cells, one per clock,
// keeping the lowest neurons*100+synapses; the winning cell updates totals.
// The next neuron is taken once the result sits in the output register;
// a stalled result holds there and the block waits before loading the next.
// Reset clears all counters and per-node totals and sets mode 0,
// node_count 1 and neurons_per_node 0.
module network_partition_assigner
    import nwpa_pkg::*;
#(
    parameter int NODES      = 16,
    parameter int GROUP_SIZE = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [SYN_W-1:0] syn_count,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [OUT_W-1:0] node,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data
);

    localparam int POS_W = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_STEP,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } state_t;

    state_t                state_reg;
    logic [1:0]            mode_reg;
    logic [4:0]            node_count_reg;
    logic [TOT_W-1:0]      npn_reg;
    logic [TOT_W-1:0]      counter_reg;
    logic [NODE_IDX_W-1:0] current_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [NODE_IDX_W-1:0] cnt_reg;
    logic [NODE_IDX_W-1:0] sel_reg;
    logic [NODE_IDX_W-1:0] res_reg;
    logic [SYN_W-1:0]      syn_reg;
    logic [QUOTA_W-1:0]    quota_reg;
    logic                  tok_vld_reg;
    logic                  out_valid_reg;
    logic [OUT_W-1:0]      node_reg;

    logic [NODE_IDX_W-1:0] cnt_eff;
    logic [NODE_IDX_W-1:0] sel_next;
    logic [NODE_IDX_W:0]   sel_inc;
    logic [NODE_IDX_W-1:0] rotate_node;
    logic                  in_acc;
    logic                  out_free;
    token_t                chain [NODES+1];
    upd_t                  upd;

    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign node      = node_reg;

    assign cnt_eff  = (32'(node_count_reg) > 32'(NODES)) ? NODE_IDX_W'(NODES)
                                                          : node_count_reg;
    assign sel_next = (current_reg < cnt_eff) ? current_reg : '0;
    assign sel_inc  = {1'b0, sel_reg} + 1'b1;
    assign rotate_node = (sel_inc >= {1'b0, cnt_reg}) ? '0 : sel_inc[NODE_IDX_W-1:0];

    assign chain[0].vld  = tok_vld_reg;
    assign chain[0].best = '0;
    assign chain[0].idx  = '0;

    assign upd.vld = (state_reg == ST_UPDATE);
    assign upd.idx = res_reg;
    assign upd.syn = syn_reg;

    for (genvar i = 0; i < NODES; i++)
    begin : g_cell
        nwpa_cell #(
            .IDX(i)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .cnt    (cnt_reg),
            .tok_in (chain[i]),
            .upd    (upd),
            .tok_out(chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_BLOCK;
            node_count_reg <= 5'd1;
            npn_reg        <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MODE:       mode_reg       <= cfg_data[1:0];
                REG_NODE_COUNT: node_count_reg <= cfg_data[4:0];
                REG_QUOTA:      npn_reg        <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            syn_reg <= syn_count;
        if (state_reg == ST_CALC)
            quota_reg <= QUOTA_W'(sel_inc) * QUOTA_W'(npn_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            counter_reg   <= '0;
            current_reg   <= '0;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            sel_reg       <= '0;
            res_reg       <= '0;
            tok_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            node_reg      <= '0;
        end
        else
        begin
            // launch the search token only for a best-fit neuron
            tok_vld_reg <= in_acc && (cnt_eff > NODE_IDX_W'(1))
                           && (mode_reg == MODE_BEST_FIT);
            if ((state_reg == ST_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        cnt_reg <= cnt_eff;
                        sel_reg <= sel_next;
                        if (cnt_eff <= NODE_IDX_W'(1))
                        begin
                            res_reg   <= '0;
                            state_reg <= ST_DONE;
                        end
                        else if (mode_reg == MODE_BEST_FIT)
                            state_reg <= ST_SCAN;
                        else
                            state_reg <= ST_CALC;
                    end
                end
                ST_CALC:
                begin
                    counter_reg <= sat_add(counter_reg, TOT_W'(1));
                    res_reg     <= sel_reg;
                    case (mode_reg)
                        MODE_RR:
                        begin
                            current_reg <= rotate_node;
                            state_reg   <= ST_DONE;
                        end
                        MODE_GROUP_RR:
                        begin
                            if (pos_reg >= POS_W'(GROUP_SIZE - 1))
                            begin
                                current_reg <= rotate_node;
                                pos_reg     <= '0;
                            end
                            else
                            begin
                                current_reg <= sel_reg;
                                pos_reg     <= pos_reg + 1'b1;
                            end
                            state_reg <= ST_DONE;
                        end
                        default:
                            state_reg <= ST_STEP;
                    endcase
                end
                ST_STEP:
                begin
                    // advance once the running count reaches this node's quota, unless this is the last node
                    if ((QUOTA_W'(counter_reg) >= quota_reg) && (sel_inc < {1'b0, cnt_reg}))
                        current_reg <= sel_inc[NODE_IDX_W-1:0];
                    else
                        current_reg <= sel_reg;
                    state_reg <= ST_DONE;
                end
                ST_SCAN:
                begin
                    if (chain[NODES].vld)
                    begin
                        res_reg     <= chain[NODES].idx;
                        counter_reg <= sat_add(counter_reg, TOT_W'(1));
                        state_reg   <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                    state_reg <= ST_DONE;
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        node_reg  <= res_reg[OUT_W-1:0];
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[rtl/core/nwpa_cell.sv]
module nwpa_cell
    import nwpa_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [NODE_IDX_W-1:0] cnt,
    input  token_t                tok_in,
    input  upd_t                  upd,
    output token_t                tok_out
);

    logic [TOT_W-1:0]  neuron_reg;
    logic [TOT_W-1:0]  neuron_next;
    logic [TOT_W-1:0]  syn_reg;
    logic [TOT_W-1:0]  syn_next;
    logic [LOAD_W-1:0] load_reg;
    logic [LOAD_W-1:0] load_next;
    token_t            tok_reg;
    token_t            tok_next;
    logic              active;
    logic              hit;

    assign active = (32'(IDX) < 32'(cnt));
    assign hit    = upd.vld && (32'(IDX) == 32'(upd.idx));

    always_comb
    begin
        neuron_next = neuron_reg;
        syn_next    = syn_reg;
        if (hit)
        begin
            neuron_next = sat_add(neuron_reg, TOT_W'(1));
            syn_next    = sat_add(syn_reg, TOT_W'(upd.syn));
        end
    end

    // weighted load is registered, so it catches up with the totals in the next cycle
    assign load_next = LOAD_W'(neuron_reg) * LOAD_W'(LOAD_WEIGHT) + LOAD_W'(syn_reg);

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.vld && active && ((IDX == 0) || (load_reg < tok_in.best)))
        begin
            tok_next.best = load_reg;
            tok_next.idx  = NODE_IDX_W'(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neuron_reg <= '0;
            syn_reg    <= '0;
            load_reg   <= '0;
            tok_reg    <= '0;
        end
        else
        begin
            neuron_reg <= neuron_next;
            syn_reg    <= syn_next;
            load_reg   <= load_next;
            tok_reg    <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

[tb/sv/network_partition_assigner_test.sv]
module network_partition_assigner_test;
    import nwpa_pkg::*;

    localparam int NODE_SLOTS   = 16;
    localparam int GROUP_LEN    = 32;
    localparam int RANDOM_ITEMS = 700;
    localparam int QUIET_LIMIT  = 3000;
    localparam int LONG_HOLD    = 300;
    localparam logic [63:0] NEURON_WEIGHT = 64'd100;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [SYN_W-1:0] syn_count = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [OUT_W-1:0] node;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index = REG_MODE;
    logic [31:0]      cfg_data = '0;

    // predictor copy of registers and state
    logic [1:0]  cfg_mode;
    logic [4:0]  cfg_nodes;
    logic [31:0] cfg_quota;
    logic [31:0] placed_total;
    logic [3:0]  cursor_node;
    logic [4:0]  group_pos;
    logic [31:0] node_neurons [NODE_SLOTS];
    logic [31:0] node_synapses [NODE_SLOTS];

    logic [SYN_W-1:0] neuron_backlog [$];
    logic [OUT_W-1:0] pending_nodes [$];

    int error_count = 0;
    int neurons_placed = 0;
    int nodes_checked = 0;
    int queued_total = 0;
    int phase_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int holds_requested = 0;
    int holds_done = 0;

    network_partition_assigner DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .syn_count     (syn_count),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .node          (node),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic [31:0] bump(input logic [31:0] a, input logic [31:0] b);
        return (a > 32'hFFFF_FFFF - b) ? 32'hFFFF_FFFF : a + b;
    endfunction

    function automatic logic [3:0] place_neuron(input logic [SYN_W-1:0] syn);
        int unsigned active;
        int unsigned i;
        logic [63:0] load;
        logic [63:0] best_load;
        logic [63:0] quota;
        logic [3:0]  pick;
        active = (cfg_nodes > NODE_SLOTS) ? NODE_SLOTS : cfg_nodes;
        pick = '0;
        best_load = '0;
        if (active <= 1)
            return 4'd0;
        placed_total = bump(placed_total, 32'd1);
        if (cfg_mode == MODE_BEST_FIT)
        begin
            for (i = 0; i < active; i++)
            begin
                load = 64'(node_neurons[i]) * NEURON_WEIGHT + 64'(node_synapses[i]);
                if (i == 0 || load < best_load)
                begin
                    best_load = load;
                    pick = 4'(i);
                end
            end
            node_neurons[pick] = bump(node_neurons[pick], 32'd1);
            node_synapses[pick] = bump(node_synapses[pick], {16'd0, syn});
        end
        else
        begin
            // fall back to node 0 if the count shrank under the cursor
            pick = (cursor_node < active) ? cursor_node : 4'd0;
            case (cfg_mode)
                MODE_BLOCK:
                begin
                    quota = (64'(pick) + 64'd1) * 64'(cfg_quota);
                    if (64'(placed_total) >= quota && pick + 1 < active)
                        cursor_node = pick + 4'd1;
                    else
                        cursor_node = pick;
                end
                MODE_RR:
                    cursor_node = (pick + 1 >= active) ? 4'd0 : pick + 4'd1;
                default:
                begin
                    if (group_pos >= GROUP_LEN - 1)
                    begin
                        cursor_node = (pick + 1 >= active) ? 4'd0 : pick + 4'd1;
                        group_pos = '0;
                    end
                    else
                    begin
                        cursor_node = pick;
                        group_pos = group_pos + 5'd1;
                    end
                end
            endcase
        end
        return pick;
    endfunction

    function automatic int idle_length(input int pct);
        int roll;
        roll = $urandom_range(99);
        if (roll >= pct)
            return 0;
        roll = $urandom_range(99);
        if (roll < 70)
            return $urandom_range(3, 1);
        if (roll < 95)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [SYN_W-1:0] random_synapses();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(64));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_error(input string what);
        $display("ERROR at %0t: %s", $time, what);
        error_count++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_neuron(input logic [SYN_W-1:0] syn);
        neuron_backlog = {neuron_backlog, syn};
        queued_total++;
    endtask

    // wait until every queued neuron is placed and every node word is back
    task automatic drain();
        while (nodes_checked < queued_total || pending_nodes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // sender
    always @(posedge clk)
    begin
        int gap_left;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (neuron_backlog.size() != 0)
            begin
                in_valid  <= 1'b1;
                syn_count <= neuron_backlog.pop_front();
                gap_left = idle_length(send_idle_pct);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver
    always @(posedge clk)
    begin
        int stall_left;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (holds_done != holds_requested)
            begin
                holds_done++;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = idle_length(recv_idle_pct);
            end
        end
    end

    // monitor and predictor update
    always @(posedge clk)
    begin
        logic [OUT_W-1:0] want;
        if (!rst_n)
        begin
            cfg_mode     = MODE_BLOCK;
            cfg_nodes    = 5'd1;
            cfg_quota    = '0;
            placed_total = '0;
            cursor_node  = '0;
            group_pos    = '0;
            for (int i = 0; i < NODE_SLOTS; i++)
            begin
                node_neurons[i]  = '0;
                node_synapses[i] = '0;
            end
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                nodes_checked++;
                if (pending_nodes.size() == 0)
                    report_error($sformatf("node word %0d with no neuron waiting", node));
                else
                begin
                    want = pending_nodes.pop_front();
                    if (node !== want)
                        report_error($sformatf("node %0d, expected %0d (result %0d)",
                                               node, want, nodes_checked));
                end
            end
            if (in_valid && !in_stall)
            begin
                pending_nodes = {pending_nodes, place_neuron(syn_count)};
                neurons_placed++;
            end
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    REG_MODE:       cfg_mode = cfg_data[1:0];
                    REG_NODE_COUNT: cfg_nodes = cfg_data[4:0];
                    REG_QUOTA:      cfg_quota = cfg_data;
                    default: ;
                endcase
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        int quiet;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("Watchdog: no handshake for %0d cycles, %0d node words outstanding",
                     quiet, pending_nodes.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int random_sent;
        int batch;
        logic [1:0] next_mode;
        random_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single node after reset
        queue_neuron(16'h0000);
        queue_neuron(16'hFFFF);
        drain();

        write_reg(REG_MODE, 32'(MODE_RR));
        write_reg(REG_NODE_COUNT, 32'd5);
        for (int i = 0; i < 7; i++)
            queue_neuron(16'(1 << (2 * i)));
        drain();

        // shrink count below the cursor
        write_reg(REG_NODE_COUNT, 32'd2);
        queue_neuron(16'h5555);
        queue_neuron(16'hAAAA);
        drain();

        write_reg(REG_NODE_COUNT, 32'd0);
        queue_neuron(16'h1234);
        drain();

        // oversized count, zero quota
        write_reg(REG_NODE_COUNT, 32'd31);
        write_reg(REG_MODE, 32'(MODE_BLOCK));
        write_reg(REG_QUOTA, 32'd0);
        repeat (3) queue_neuron(16'h00FF);
        drain();

        write_reg(REG_NODE_COUNT, 32'd16);
        write_reg(REG_QUOTA, 32'hFFFF_FFFF);
        queue_neuron(16'hFF00);
        queue_neuron(16'h0001);
        drain();

        write_reg(REG_MODE, 32'(MODE_BEST_FIT));
        queue_neuron(16'h0000);
        queue_neuron(16'hFFFF);
        queue_neuron(16'h0001);
        queue_neuron(16'h8000);
        drain();

        write_reg(REG_MODE, 32'(MODE_GROUP_RR));
        write_reg(REG_NODE_COUNT, 32'd3);
        repeat (4) queue_neuron(16'h0F0F);
        drain();

        while (random_sent < RANDOM_ITEMS)
        begin
            phase_count++;
            drain();
            case (phase_count % 4)
                0: next_mode = MODE_BLOCK;
                1: next_mode = MODE_RR;
                2: next_mode = MODE_GROUP_RR;
                default: next_mode = MODE_BEST_FIT;
            endcase
            if ($urandom_range(3) == 0)
                next_mode = 2'($urandom_range(3));
            write_reg(REG_MODE, 32'(next_mode));
            if ($urandom_range(3) != 0)
                case ($urandom_range(9))
                    0: write_reg(REG_NODE_COUNT, 32'($urandom_range(1)));
                    1: write_reg(REG_NODE_COUNT, 32'($urandom_range(31, 17)));
                    default: write_reg(REG_NODE_COUNT, 32'($urandom_range(16, 2)));
                endcase
            if (next_mode == MODE_BLOCK || $urandom_range(3) == 0)
                case ($urandom_range(7))
                    0: write_reg(REG_QUOTA, 32'd0);
                    1: write_reg(REG_QUOTA, 32'hFFFF_FFFF);
                    2: write_reg(REG_QUOTA, $urandom);
                    default: write_reg(REG_QUOTA, 32'($urandom_range(placed_total / 8 + 2, 1)));
                endcase
            case ($urandom_range(2))
                0: send_idle_pct = 0;
                1: send_idle_pct = 25;
                default: send_idle_pct = 60;
            endcase
            case ($urandom_range(2))
                0: recv_idle_pct = 0;
                1: recv_idle_pct = 25;
                default: recv_idle_pct = 60;
            endcase
            // hold the output off while neurons keep coming
            if (phase_count == 3)
                holds_requested++;
            batch = $urandom_range(60, 20);
            repeat (batch) queue_neuron(random_synapses());
            random_sent += batch;
        end

        drain();
        repeat (40) @(posedge clk);
        $display("Placed %0d neurons, checked %0d node words, across %0d random settings",
                 neurons_placed, nodes_checked, phase_count);
        $display("Covered all four modes, node counts 0 to 31, quotas 0 to max and stale cursors");
        if (error_count == 0 && pending_nodes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/nwpa_pkg.sv
rtl/core/nwpa_cell.sv
rtl/core/network_partition_assigner.sv
tb/sv/network_partition_assigner_test.sv
